[hw/rtl/srat_pkg.sv]
package srat_pkg;

   localparam int unsigned HDR_BYTES      = 7;
   localparam int unsigned LEN_BIAS       = 4;
   localparam int unsigned LEN_POS_OFFSET = HDR_BYTES - LEN_BIAS;
   localparam logic [7:0]  STATUS_ACK     = 8'h01;

   typedef enum logic [1:0] {
      FUNC_ACK   = 2'd0,
      FUNC_QUERY = 2'd1,
      FUNC_CLEAR = 2'd2
   } func_type;

   typedef enum logic [1:0] {
      KIND_SUMMARY = 2'd0,
      KIND_QUERY   = 2'd1,
      KIND_CLEAR   = 2'd2
   } kind_type;

   typedef enum logic [1:0] {
      ST_CLEAR,
      ST_RUN,
      ST_QUERY
   } state_type;

   typedef struct packed {
      logic [1:0]  func;
      logic [7:0]  ack_byte;
      logic        last_byte;
      logic [11:0] query_index;
   } req_type;

   typedef struct packed {
      logic [1:0]  kind;
      logic [31:0] next_pid;
      logic        all_done;
      logic        short_packet;
      logic        entry_acked;
   } rsp_type;

endpackage

[hw/rtl/selective_repeat_ack_tracker.sv]
// Results: an ACK summary is registered and appears in the cycle after its last byte
// is taken; a query answer is read from the acked-bit memory and then registered.
// Throughput: one ACK byte per cycle unless the output stalls; a query stalls input
// in ST_QUERY; a clear walks every acked-bit entry, one per cycle, then reports.
// Reset: synchronous; after reset the same clearing pass runs with
// the input stalled and no result is given.
module selective_repeat_ack_tracker #(
   parameter int MAX_PACKETS  = 4096,
   parameter int PACKET_BYTES = 1024
) (
   input  logic             clock,
   input  logic             reset,
   input  logic             req_valid,
   output logic             req_stall,
   input  srat_pkg::req_type req_data,
   output logic             rsp_valid,
   input  logic             rsp_stall,
   output srat_pkg::rsp_type rsp_data,
   input  logic             csr_valid,
   output logic             csr_ready,
   input  logic [12:0]      csr_data
);
   import srat_pkg::*;

   localparam int AddrW = (MAX_PACKETS > 1) ? $clog2(MAX_PACKETS) : 1;
   localparam int PosW  = $clog2(PACKET_BYTES + 1);

   state_type state_ff, state_in;
   logic [AddrW-1:0] clr_idx_ff, clr_idx_in;
   logic clr_report_ff, clr_report_in;
   logic [12:0] num_packets_ff;
   logic [12:0] acked_below_ff, acked_below_in;
   logic [PosW-1:0] pos_ff, pos_in;
   logic [15:0] len_ff, len_in;
   logic [31:0] pid_ff, pid_in;
   logic nak_ff, nak_in;
   logic [31:0] next_send_ff, next_send_in;
   logic [32:0] cur_id_ff, cur_id_in;
   logic q_ok_ff, q_ok_in;
   logic q_below_ff, q_below_in;
   logic rsp_valid_ff, rsp_valid_in;
   rsp_type rsp_data_ff, rsp_data_in;

   logic [12:0] n_eff;
   logic out_free, accept, clr_last;
   logic is_ack, is_query, is_clear;
   logic map_wr_en, ram_wr_en, map_rd_en, ram_rd_data;
   logic [AddrW-1:0] map_wr_addr, ram_wr_addr;
   logic ram_wr_data;
   logic [31:0] pid_new, pos_rel;
   logic summary_load, short_pkt;

   assign n_eff = (32'(num_packets_ff) < 32'(MAX_PACKETS)) ? num_packets_ff
                                                          : 13'(MAX_PACKETS);
   assign out_free = !rsp_valid_ff || !rsp_stall;
   assign accept   = req_valid && !req_stall;
   assign is_ack   = req_data.func == FUNC_ACK;
   assign is_query = req_data.func == FUNC_QUERY;
   assign is_clear = req_data.func == FUNC_CLEAR;
   assign clr_last = clr_idx_ff == AddrW'(MAX_PACKETS - 1);
   assign csr_ready = 1'b1;

   always_comb begin
      state_in      = state_ff;
      clr_idx_in    = clr_idx_ff;
      clr_report_in = clr_report_ff;
      unique case (state_ff)
         ST_CLEAR: begin
            clr_idx_in = clr_idx_ff + AddrW'(1);
            if (clr_last) begin
               state_in   = ST_RUN;
               clr_idx_in = '0;
            end
         end
         ST_RUN: begin
            if (accept && is_clear) begin
               state_in      = ST_CLEAR;
               clr_report_in = 1'b1;
               clr_idx_in    = '0;
            end else if (accept && is_query) begin
               state_in = ST_QUERY;
            end
         end
         ST_QUERY: begin
            state_in = ST_RUN;
         end
         default: begin
            state_in = ST_RUN;
         end
      endcase
   end

   always_comb begin
      req_stall = 1'b1;
      unique case (state_ff)
         ST_RUN:   req_stall = !out_free;
         ST_CLEAR: req_stall = 1'b1;
         ST_QUERY: req_stall = 1'b1;
         default:  req_stall = 1'b1;
      endcase
   end

   always_comb begin
      pos_in         = pos_ff;
      len_in         = len_ff;
      pid_in         = pid_ff;
      nak_in         = nak_ff;
      next_send_in   = next_send_ff;
      cur_id_in      = cur_id_ff;
      acked_below_in = acked_below_ff;
      map_wr_en      = 1'b0;
      map_wr_addr    = AddrW'(cur_id_ff);
      pid_new        = {pid_ff[23:0], req_data.ack_byte};
      pos_rel        = 32'(pos_ff) - 32'(LEN_POS_OFFSET);
      summary_load   = 1'b0;
      short_pkt      = 1'b0;
      if (accept && is_ack) begin
         if (32'(pos_ff) < 32'(PACKET_BYTES)) begin
            pos_in = pos_ff + PosW'(1);
            if (pos_ff == '0) begin
               pos_in = PosW'(1);
            end else if (32'(pos_ff) <= 32'(2)) begin
               len_in = {len_ff[7:0], req_data.ack_byte};
            end else if (32'(pos_ff) < 32'(HDR_BYTES)) begin
               pid_in = pid_new;
               if (32'(pos_ff) == 32'(HDR_BYTES - 1)) begin
                  if (pid_new <= 32'(n_eff) && pid_new > 32'(acked_below_ff)) begin
                     acked_below_in = 13'(pid_new);
                  end
                  next_send_in = pid_new;
                  cur_id_in    = {1'b0, pid_new};
               end
            end else begin
               cur_id_in = cur_id_ff + 33'(1);
               if (pos_rel < 32'(len_ff) && cur_id_ff < 33'(n_eff)) begin
                  if (req_data.ack_byte == STATUS_ACK) begin
                     map_wr_en = 1'b1;
                  end else if (!nak_ff) begin
                     next_send_in = cur_id_ff[31:0];
                     nak_in       = 1'b1;
                  end
               end
            end
         end
         if (req_data.last_byte) begin
            summary_load = 1'b1;
            short_pkt    = 32'(pos_in) < 32'(HDR_BYTES);
         end
      end
      if (accept && is_clear) begin
         acked_below_in = '0;
      end
   end

   always_comb begin
      rsp_data_in = rsp_data_ff;
      rsp_valid_in = rsp_valid_ff && rsp_stall;
      if (summary_load) begin
         rsp_valid_in              = 1'b1;
         rsp_data_in               = '0;
         rsp_data_in.kind          = KIND_SUMMARY;
         rsp_data_in.short_packet  = short_pkt;
         if (!short_pkt) begin
            rsp_data_in.next_pid = next_send_in;
            rsp_data_in.all_done = pid_in == 32'(n_eff);
         end
      end else if (state_ff == ST_QUERY) begin
         rsp_valid_in             = 1'b1;
         rsp_data_in              = '0;
         rsp_data_in.kind         = KIND_QUERY;
         rsp_data_in.entry_acked  = q_ok_ff && (q_below_ff || ram_rd_data);
      end else if (state_ff == ST_CLEAR && clr_last && clr_report_ff) begin
         rsp_valid_in     = 1'b1;
         rsp_data_in      = '0;
         rsp_data_in.kind = KIND_CLEAR;
      end
   end

   assign q_ok_in    = 32'(req_data.query_index) < 32'(MAX_PACKETS);
   assign q_below_in = 13'(req_data.query_index) < acked_below_ff;
   assign map_rd_en  = accept && is_query;

   assign ram_wr_en   = (state_ff == ST_CLEAR) || map_wr_en;
   assign ram_wr_addr = (state_ff == ST_CLEAR) ? clr_idx_ff : map_wr_addr;
   assign ram_wr_data = state_ff != ST_CLEAR;

   srat_ram #(
      .WIDTH (1),
      .DEPTH (MAX_PACKETS)
   ) u_map (
      .clock   (clock),
      .wr_en   (ram_wr_en),
      .wr_addr (ram_wr_addr),
      .wr_data (ram_wr_data),
      .rd_en   (map_rd_en),
      .rd_addr (AddrW'(req_data.query_index)),
      .rd_data (ram_rd_data)
   );

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff       <= ST_CLEAR;
         clr_idx_ff     <= '0;
         clr_report_ff  <= 1'b0;
         num_packets_ff <= '0;
         acked_below_ff <= '0;
         pos_ff         <= '0;
         len_ff         <= '0;
         pid_ff         <= '0;
         nak_ff         <= 1'b0;
         next_send_ff   <= '0;
         cur_id_ff      <= '0;
         rsp_valid_ff   <= 1'b0;
      end else begin
         state_ff       <= state_in;
         clr_idx_ff     <= clr_idx_in;
         clr_report_ff  <= clr_report_in;
         acked_below_ff <= acked_below_in;
         rsp_valid_ff   <= rsp_valid_in;
         if (csr_valid && csr_ready) begin
            num_packets_ff <= csr_data;
         end
         if (summary_load) begin
            pos_ff       <= '0;
            len_ff       <= '0;
            pid_ff       <= '0;
            nak_ff       <= 1'b0;
            next_send_ff <= '0;
            cur_id_ff    <= '0;
         end else begin
            pos_ff       <= pos_in;
            len_ff       <= len_in;
            pid_ff       <= pid_in;
            nak_ff       <= nak_in;
            next_send_ff <= next_send_in;
            cur_id_ff    <= cur_id_in;
         end
      end
   end

   always_ff @(posedge clock) begin
      rsp_data_ff <= rsp_data_in;
      if (map_rd_en) begin
         q_ok_ff    <= q_ok_in;
         q_below_ff <= q_below_in;
      end
   end

   assign rsp_valid = rsp_valid_ff;
   assign rsp_data  = rsp_data_ff;

endmodule

[hw/rtl/srat_ram.sv]
module srat_ram #(
   parameter int WIDTH = 1,
   parameter int DEPTH = 4096,
   localparam int AddrW = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
   input  logic             clock,
   input  logic             wr_en,
   input  logic [AddrW-1:0] wr_addr,
   input  logic [WIDTH-1:0] wr_data,
   input  logic             rd_en,
   input  logic [AddrW-1:0] rd_addr,
   output logic [WIDTH-1:0] rd_data
);

   logic [WIDTH-1:0] mem [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem[wr_addr] <= wr_data;
      end
      if (rd_en) begin
         rd_data_ff <= mem[rd_addr];
      end
   end

   assign rd_data = rd_data_ff;

endmodule
